// ===== sv/olist_pkg.sv =====
// Shared constants and types for the ordered list insert block.
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

    // List capacity and derived widths
    localparam int DEPTH  = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Fixed field widths of the stream payloads
    localparam int POS_W      = 6;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = VAL_W;
    localparam int M_TUSER_W  = 1 + STATUS_W;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_ELEMENT = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_DUMP  = 3'b100
    } state_t;

    typedef struct packed {
        logic                last;
        logic [STATUS_W-1:0] status;
        logic                dir;
    } meta_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        meta_t            meta;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/olist_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module olist_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/ordered_list_insert_at_position.sv =====
// Top level of the ordered list insert block: control, list RAM and output queue.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values, held in one RAM.
// Input channel (s_*): one beat carries an insert position and a value.
// Result channel (m_*): beats of the list dump, or a single status beat.
// A position above the current count yields one beat with status "invalid";
// a full list yields one beat with status "full"; both leave the list as is.
// An accepted insert moves entries at and above the position up by one, one
// entry per cycle through the RAM's read and write ports (each entry is read,
// then written back one slot higher; the new value is placed after the last
// write-back, and an insert at the tail skips the move), then streams the list
// front to back and back to front, one beat per cycle while the output queue
// has room: 2 * count beats.
// The shift loop and the single RAM read port set how long a full-size insert
// at the head takes. m_tlast marks the last beat caused by an input. Reset
// empties the list; RAM contents are never cleared, only entries below the
// count are ever read. When the receiver stalls, a two-beat output queue
// absorbs the in-flight RAM read and the dump pauses; a new insert is taken
// once the dump is issued and a queue slot is free.
module ordered_list_insert_at_position (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [5:0] insert_position, [37:6] new_value, upper bits zero
    input  wire logic [olist_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] element_value
    output logic      [olist_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] pass_direction, [2:1] status
    output logic      [olist_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                   m_tlast
);
    import olist_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  src_reg, src_next;       // target slot of the next entry to move up
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic              shwr_valid_reg, shwr_valid_next;
    logic [ADDR_W-1:0] shwr_addr_reg, shwr_addr_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              back_reg, back_next;     // backward pass of the dump
    logic              pend_valid_reg, pend_valid_next;
    meta_t             pend_meta_reg, pend_meta_next;

    // two-entry output queue
    result_t           fifo_reg [2];
    logic              fifo_wptr_reg, fifo_rptr_reg;
    logic [1:0]        fifo_cnt_reg;

    // RAM port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_val;
    logic              accept;
    logic              pos_bad;
    logic              list_full;
    logic              pop;
    logic              push;
    logic [2:0]        occupancy;
    logic              can_issue;
    logic [CNT_W-1:0]  src_m1;
    logic [CNT_W-1:0]  last_idx;
    result_t           push_entry;

    olist_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Input decode
    assign in_pos    = s_tdata[POS_W-1:0];
    assign in_val    = s_tdata[POS_W +: VAL_W];
    assign pos_bad   = in_pos > POS_W'(count_reg);
    assign list_full = count_reg == CNT_W'(DEPTH);

    // Take an insert only when idle and a queue slot is reserved for its first beat
    assign s_tready = (state_reg == ST_IDLE) && !pend_valid_reg && (fifo_cnt_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;

    // Output side
    assign m_tvalid = fifo_cnt_reg != 2'd0;
    assign m_tdata  = fifo_reg[fifo_rptr_reg].value;
    assign m_tuser  = {fifo_reg[fifo_rptr_reg].meta.status, fifo_reg[fifo_rptr_reg].meta.dir};
    assign m_tlast  = fifo_reg[fifo_rptr_reg].meta.last;
    assign pop      = m_tvalid && m_tready;
    assign push     = pend_valid_reg;

    // Queue slots taken or promised; issue a read only if one stays free
    assign occupancy = {1'b0, fifo_cnt_reg} + {2'b00, pend_valid_reg} - {2'b00, pop};
    assign can_issue = occupancy < 3'd2;

    assign src_m1   = src_reg - 1'b1;
    assign last_idx = count_reg - 1'b1;

    // Rejected inserts carry a zero value; dump beats take the RAM read data
    assign push_entry.value = (pend_meta_reg.status == STATUS_ELEMENT) ? ram_rdata : '0;
    assign push_entry.meta  = pend_meta_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        src_next        = src_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        shwr_valid_next = shwr_valid_reg;
        shwr_addr_next  = shwr_addr_reg;
        rd_idx_next     = rd_idx_reg;
        back_next       = back_reg;
        pend_valid_next = 1'b0;
        pend_meta_next  = pend_meta_reg;
        ram_we          = 1'b0;
        ram_waddr       = shwr_addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = rd_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (pos_bad) begin
                        pend_valid_next = 1'b1;
                        pend_meta_next  = '{last: 1'b1, status: STATUS_INVALID, dir: 1'b0};
                    end else if (list_full) begin
                        pend_valid_next = 1'b1;
                        pend_meta_next  = '{last: 1'b1, status: STATUS_FULL, dir: 1'b0};
                    end else begin
                        src_next        = count_reg;
                        pos_next        = in_pos[CNT_W-1:0];
                        val_next        = in_val;
                        shwr_valid_next = 1'b0;
                        state_next      = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                // write back the entry read last cycle, one slot higher
                if (shwr_valid_reg) begin
                    ram_we = 1'b1;
                end
                if (src_reg > pos_reg) begin
                    ram_raddr       = src_m1[ADDR_W-1:0];
                    shwr_valid_next = 1'b1;
                    shwr_addr_next  = src_reg[ADDR_W-1:0];
                    src_next        = src_m1;
                end else begin
                    shwr_valid_next = 1'b0;
                    if (!shwr_valid_reg) begin
                        // move done: place the new value and start the dump
                        ram_we      = 1'b1;
                        ram_waddr   = pos_reg[ADDR_W-1:0];
                        ram_wdata   = val_reg;
                        count_next  = count_reg + 1'b1;
                        rd_idx_next = '0;
                        back_next   = 1'b0;
                        state_next  = ST_DUMP;
                    end
                end
            end
            ST_DUMP: begin
                if (can_issue) begin
                    pend_valid_next = 1'b1;
                    pend_meta_next  = '{last:   back_reg && (rd_idx_reg == '0),
                                        status: STATUS_ELEMENT,
                                        dir:    back_reg};
                    if (!back_reg) begin
                        if (CNT_W'(rd_idx_reg) == last_idx) begin
                            back_next = 1'b1;
                        end else begin
                            rd_idx_next = rd_idx_reg + 1'b1;
                        end
                    end else begin
                        if (rd_idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            rd_idx_next = rd_idx_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            shwr_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            back_reg       <= 1'b0;
            fifo_wptr_reg  <= 1'b0;
            fifo_rptr_reg  <= 1'b0;
            fifo_cnt_reg   <= 2'd0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            shwr_valid_reg <= shwr_valid_next;
            pend_valid_reg <= pend_valid_next;
            back_reg       <= back_next;
            if (push) begin
                fifo_wptr_reg <= ~fifo_wptr_reg;
            end
            if (pop) begin
                fifo_rptr_reg <= ~fifo_rptr_reg;
            end
            fifo_cnt_reg <= fifo_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        src_reg       <= src_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        shwr_addr_reg <= shwr_addr_next;
        rd_idx_reg    <= rd_idx_next;
        pend_meta_reg <= pend_meta_next;
        if (push) begin
            fifo_reg[fifo_wptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire
